[rtl/core/mwe_pkg.sv]
`timescale 1ns / 1ps
package mwe_pkg;

  localparam int ADDR_BITS_DEF   = 9;
  localparam int DATA_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_W           = 16;
  localparam logic [CFG_W-1:0] TICKS_RESET = 16'd16;

  // opcode field after the start bit
  localparam logic [1:0] OPC_EXT   = 2'b00;
  localparam logic [1:0] OPC_WRITE = 2'b01;
  localparam logic [1:0] OPC_READ  = 2'b10;
  localparam logic [1:0] OPC_ERASE = 2'b11;

  // top two address bits of the extended opcode
  localparam logic [1:0] SUB_EWDS = 2'b00;
  localparam logic [1:0] SUB_WRAL = 2'b01;
  localparam logic [1:0] SUB_ERAL = 2'b10;
  localparam logic [1:0] SUB_EWEN = 2'b11;

  typedef struct packed {
    logic chip_select;
    logic serial_clock;
    logic data_in;
  } in_item_t;

  typedef struct packed {
    logic data_out;
    logic out_driven;
    logic busy_res;
  } out_item_t;

  // classified pin sample handed from front to back
  typedef struct packed {
    logic cs;
    logic rising;
    logic di;
  } ev_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_DATA,
    PH_READ,
    PH_ARMED
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EWEN,
    OP_EWDS,
    OP_WRITE,
    OP_ERASE,
    OP_ERAL,
    OP_WRAL
  } op_t;

endpackage

[rtl/core/mwe_fifo.sv]
`timescale 1ns / 1ps
module mwe_fifo import mwe_pkg::*; #(
  parameter int WIDTH = 3,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/mwe_front.sv]
`timescale 1ns / 1ps
module mwe_front import mwe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  input  logic     cq_full,
  input  logic     clearing,
  output logic     cq_push,
  output ev_t      ev
);

  logic last_clk;

  // hold off requests while the array is being cleared
  assign full    = cq_full || clearing;
  assign cq_push = push && !full;

  assign ev.cs     = in_item.chip_select;
  assign ev.rising = in_item.serial_clock && !last_clk;
  assign ev.di     = in_item.data_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clk <= 1'b0;
    end else if (cq_push) begin
      last_clk <= in_item.serial_clock;
    end
  end

endmodule

[rtl/core/mwe_back.sv]
`timescale 1ns / 1ps
module mwe_back import mwe_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             cq_empty,
  input  ev_t              ev,
  output logic             cq_pop,
  input  logic             rq_full,
  output logic             rq_push,
  output out_item_t        res,
  output logic             clearing
);

  localparam int NCELLS   = 1 << ADDR_BITS;
  localparam int CMD_BITS = 2 + ADDR_BITS;
  localparam int SHIFT_W  = (CMD_BITS > DATA_BITS) ? CMD_BITS : DATA_BITS;
  localparam int BC_W     = $clog2(SHIFT_W + 1);
  localparam int FI_W     = ADDR_BITS + 1;
  localparam logic [BC_W-1:0]  BC_CMD     = BC_W'(CMD_BITS);
  localparam logic [BC_W-1:0]  BC_SHORT   = BC_W'(CMD_BITS - 1);
  localparam logic [BC_W-1:0]  BC_DATA    = BC_W'(DATA_BITS);
  localparam logic [CFG_W-1:0] FILL_TICKS = CFG_W'(NCELLS);

  // storage
  logic [DATA_BITS-1:0] cells [NCELLS];
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [DATA_BITS-1:0] mem_wdata;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [DATA_BITS-1:0] rd_data;
  logic                 rd_pending;
  logic                 clr_active;
  logic [ADDR_BITS-1:0] clr_addr;

  // registers
  logic [CFG_W-1:0]     program_ticks;
  phase_t               phase, phase_next;
  logic                 wel, wel_next;
  logic [BC_W-1:0]      bit_count, bit_count_next;
  logic [SHIFT_W-1:0]   command_shift, command_shift_next;
  logic [DATA_BITS-1:0] read_shift, read_shift_next;
  logic [CFG_W-1:0]     busy_count, busy_count_next;
  logic [FI_W-1:0]      fill_index, fill_index_next;
  logic                 fill_active, fill_active_next;
  logic [DATA_BITS-1:0] fill_data, fill_data_next;
  op_t                  pending_op, pending_op_next;
  logic [ADDR_BITS-1:0] cmd_addr, cmd_addr_next;
  logic                 read_bit, read_bit_next;
  logic                 status_flag, status_flag_next;

  // per-request helpers
  logic                 step;
  logic                 rise;
  logic                 fall;
  logic [CFG_W-1:0]     ticks_eff;
  logic [CFG_W-1:0]     busy_tick;
  logic [FI_W-1:0]      fill_idx_tick;
  logic                 fill_act_tick;
  logic                 fill_we;
  logic [CMD_BITS-1:0]  cmd_n;
  logic [DATA_BITS-1:0] dat_n;
  logic [BC_W-1:0]      bc_inc;
  logic [1:0]           op_dec;
  logic [1:0]           sub_dec;
  logic [1:0]           op_short;
  logic [1:0]           sub_short;
  op_t                  pend_dec;
  op_t                  exec_op;
  logic                 exec_we;
  logic [DATA_BITS-1:0] exec_wdata;

  assign step     = !cq_empty && !rq_full && !clr_active;
  assign cq_pop   = step;
  assign rq_push  = step;
  assign clearing = clr_active;
  assign rise     = step && ev.cs && ev.rising;
  assign fall     = step && !ev.cs;

  assign ticks_eff = (program_ticks == '0) ? CFG_W'(1) : program_ticks;
  assign cmd_n     = {command_shift[CMD_BITS-2:0], ev.di};
  assign dat_n     = {command_shift[DATA_BITS-2:0], ev.di};
  assign bc_inc    = bit_count + 1'b1;
  assign op_dec    = cmd_n[CMD_BITS-1 -: 2];
  assign sub_dec   = cmd_n[ADDR_BITS-1 -: 2];
  // one address bit short: the opcode sits one place lower
  assign op_short  = command_shift[ADDR_BITS -: 2];
  assign sub_short = command_shift[ADDR_BITS-2 -: 2];

  // self-timed countdown and fill, one cell per request
  always_comb begin
    busy_tick     = busy_count;
    fill_idx_tick = fill_index;
    fill_act_tick = fill_active;
    fill_we       = 1'b0;
    if (busy_count != '0) begin
      if (fill_active) begin
        if (!fill_index[ADDR_BITS]) begin
          fill_we       = 1'b1;
          fill_idx_tick = fill_index + 1'b1;
        end
        if (fill_idx_tick[ADDR_BITS]) begin
          fill_act_tick = 1'b0;
        end
      end
      busy_tick = busy_count - 1'b1;
    end
  end

  always_comb begin
    case (op_dec)
      OPC_WRITE: pend_dec = OP_WRITE;
      OPC_ERASE: pend_dec = OP_ERASE;
      OPC_EXT: begin
        case (sub_dec)
          SUB_EWDS: pend_dec = OP_EWDS;
          SUB_WRAL: pend_dec = OP_WRAL;
          SUB_ERAL: pend_dec = OP_ERAL;
          default:  pend_dec = OP_EWEN;
        endcase
      end
      default: pend_dec = OP_NONE;
    endcase
  end

  always_comb begin
    exec_op = OP_NONE;
    if (fall) begin
      if (phase == PH_ARMED) begin
        exec_op = pending_op;
      end else if (phase == PH_ADDR && bit_count == BC_SHORT && op_short == OPC_EXT) begin
        if (sub_short == SUB_EWEN) begin
          exec_op = OP_EWEN;
        end else if (sub_short == SUB_EWDS) begin
          exec_op = OP_EWDS;
        end
      end
    end
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (fall) begin
      phase_next = PH_IDLE;
    end else if (rise) begin
      case (phase)
        PH_IDLE: begin
          if (busy_tick == '0 && ev.di) begin
            phase_next = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (bc_inc >= BC_CMD) begin
            if (op_dec == OPC_READ) begin
              phase_next = PH_READ;
            end else if (pend_dec == OP_WRITE || pend_dec == OP_WRAL) begin
              phase_next = PH_DATA;
            end else begin
              phase_next = PH_ARMED;
            end
          end
        end
        PH_DATA: begin
          if (bc_inc >= BC_DATA) begin
            phase_next = PH_ARMED;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    wel_next           = wel;
    bit_count_next     = bit_count;
    command_shift_next = command_shift;
    read_shift_next    = read_shift;
    busy_count_next    = busy_count;
    fill_index_next    = fill_index;
    fill_active_next   = fill_active;
    fill_data_next     = fill_data;
    pending_op_next    = pending_op;
    cmd_addr_next      = cmd_addr;
    read_bit_next      = read_bit;
    status_flag_next   = status_flag;
    exec_we            = 1'b0;
    exec_wdata         = '1;
    rd_en              = 1'b0;
    rd_addr            = cmd_addr;

    if (step) begin
      busy_count_next  = busy_tick;
      fill_index_next  = fill_idx_tick;
      fill_active_next = fill_act_tick;
    end

    if (fall) begin
      case (exec_op)
        OP_EWEN: wel_next = 1'b1;
        OP_EWDS: wel_next = 1'b0;
        OP_WRITE, OP_ERASE: begin
          if (wel) begin
            exec_we          = 1'b1;
            exec_wdata       = (exec_op == OP_WRITE) ? command_shift[DATA_BITS-1:0] : '1;
            busy_count_next  = ticks_eff;
            status_flag_next = 1'b1;
          end
        end
        OP_ERAL, OP_WRAL: begin
          if (wel) begin
            fill_data_next   = (exec_op == OP_WRAL) ? command_shift[DATA_BITS-1:0] : '1;
            fill_index_next  = '0;
            fill_active_next = 1'b1;
            busy_count_next  = (ticks_eff > FILL_TICKS) ? ticks_eff : FILL_TICKS;
            status_flag_next = 1'b1;
          end
        end
        default: ;
      endcase
      bit_count_next     = '0;
      command_shift_next = '0;
      pending_op_next    = OP_NONE;
      read_bit_next      = 1'b0;
    end else if (rise) begin
      case (phase)
        PH_IDLE: begin
          if (busy_tick == '0 && ev.di) begin
            bit_count_next     = '0;
            command_shift_next = '0;
            status_flag_next   = 1'b0;
          end
        end
        PH_ADDR: begin
          if (bc_inc >= BC_CMD) begin
            cmd_addr_next      = cmd_n[ADDR_BITS-1:0];
            bit_count_next     = '0;
            command_shift_next = '0;
            if (op_dec == OPC_READ) begin
              rd_en         = 1'b1;
              rd_addr       = cmd_n[ADDR_BITS-1:0];
              read_bit_next = 1'b0;
            end else begin
              pending_op_next = pend_dec;
            end
          end else begin
            command_shift_next = SHIFT_W'(cmd_n);
            bit_count_next     = bc_inc;
          end
        end
        PH_DATA: begin
          command_shift_next = SHIFT_W'(dat_n);
          bit_count_next     = bc_inc;
        end
        PH_READ: begin
          read_bit_next   = read_shift[DATA_BITS-1];
          read_shift_next = {read_shift[DATA_BITS-2:0], 1'b0};
          if (bc_inc >= BC_DATA) begin
            // advance to the next cell, fetched for the following byte
            cmd_addr_next  = cmd_addr + 1'b1;
            rd_en          = 1'b1;
            rd_addr        = cmd_addr + 1'b1;
            bit_count_next = '0;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        default: ;
      endcase
    end

    res.busy_res   = (busy_count_next != '0);
    res.out_driven = ev.cs && (phase_next == PH_READ ||
                               (phase_next == PH_IDLE && status_flag_next));
    res.data_out   = 1'b0;
    if (ev.cs) begin
      if (phase_next == PH_READ) begin
        res.data_out = read_bit_next;
      end else if (phase_next == PH_IDLE && status_flag_next) begin
        res.data_out = (busy_count_next == '0);
      end
    end
  end

  // single write port: clearing pass, fill, or a single-cell program
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_addr;
    mem_wdata = exec_wdata;
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '1;
    end else if (step && fill_we) begin
      mem_we    = 1'b1;
      mem_waddr = fill_index[ADDR_BITS-1:0];
      mem_wdata = fill_data;
    end else if (exec_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= cells[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_ticks <= TICKS_RESET;
    end else if (cfg_write) begin
      program_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wel           <= 1'b0;
      bit_count     <= '0;
      command_shift <= '0;
      busy_count    <= '0;
      fill_index    <= '0;
      fill_active   <= 1'b0;
      pending_op    <= OP_NONE;
      read_bit      <= 1'b0;
      status_flag   <= 1'b0;
      rd_pending    <= 1'b0;
    end else begin
      phase         <= phase_next;
      wel           <= wel_next;
      bit_count     <= bit_count_next;
      command_shift <= command_shift_next;
      busy_count    <= busy_count_next;
      fill_index    <= fill_index_next;
      fill_active   <= fill_active_next;
      pending_op    <= pending_op_next;
      read_bit      <= read_bit_next;
      status_flag   <= status_flag_next;
      rd_pending    <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    fill_data <= fill_data_next;
    cmd_addr  <= cmd_addr_next;
    // load the fetched byte once rd_pending marks the array read as done
    if (rd_pending) begin
      read_shift <= rd_data;
    end else begin
      read_shift <= read_shift_next;
    end
  end

  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    fill_active |-> busy_count != '0)
    else $error("fill running with busy count at zero");

  a_read_idle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_READ |-> busy_count == '0)
    else $error("read in progress while programming");

  a_fetch_gap: assert property (@(posedge clk) disable iff (rst)
    rd_pending |=> !rd_pending)
    else $error("back-to-back cell fetches");

  a_status_cmd: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> !status_flag)
    else $error("status flag set while a command is shifting");

endmodule

[rtl/core/microwire_eeprom_device.sv]
`timescale 1ns / 1ps
// Serial three-wire EEPROM slave, byte organized, driven one pin sample at a time.
// Input channel: push/full carries in_item, one sample of select, clock and data-in.
// A request is taken at a clock edge with push high and full low.
// Result channel: empty/pop carries out_item, one result per request, in order:
// data-out level, whether it is driven, and the busy flag of the program timer.
// Configuration: cfg_write with cfg_wdata sets the program tick count at once.
// Path: a request is held in the request queue, handled by the back and held in the
// result queue until it is popped.
// Throughput: one request per cycle unless the result queue is full or a clearing pass
// runs; the edge detector in the front, the command engine in the back and the cell
// array each take one request a cycle, with at most one array write and read a cycle.
// Reset: control state clears, then the cell array is set to all ones by a
// clearing pass over all 2**ADDR_BITS cells (512 at the default), during which full is
// high. Configuration writes are taken during the pass.
// Stall: when pop stays low the result queue fills, the back stops taking requests,
// the request queue fills and full rises; nothing is dropped.
module microwire_eeprom_device import mwe_pkg::*; #(
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int DATA_BITS   = DATA_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  in_item_t         in_item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic                  cq_full;
  logic                  cq_empty;
  logic                  cq_push;
  logic                  cq_pop;
  ev_t                   ev_in;
  logic [$bits(ev_t)-1:0] cq_rdata;
  logic                  rq_full;
  logic                  rq_push;
  out_item_t             rq_wdata;
  logic [$bits(out_item_t)-1:0] rq_rdata;
  logic                  clearing;

  mwe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cq_full  (cq_full),
    .clearing (clearing),
    .cq_push  (cq_push),
    .ev       (ev_in)
  );

  mwe_fifo #(
    .WIDTH ($bits(ev_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wdata (ev_in),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  mwe_back #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_wdata (cfg_wdata),
    .cq_empty  (cq_empty),
    .ev        (ev_t'(cq_rdata)),
    .cq_pop    (cq_pop),
    .rq_full   (rq_full),
    .rq_push   (rq_push),
    .res       (rq_wdata),
    .clearing  (clearing)
  );

  mwe_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign out_item = out_item_t'(rq_rdata);

endmodule
